@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define DSPC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define DSPC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/dspc_pkg.sv @@
`default_nettype none

package dspc_pkg;

  // Number of window positions; depth code NUM_POSITIONS means no match.
  localparam int NUM_POSITIONS = 13;

  // Field and register widths.
  localparam int SAMPLE_W   = 13;
  localparam int SAFE_W     = 13;
  localparam int SLOPE_W    = 10;
  localparam int BS_W       = 4;
  localparam int DATA_W     = 13;
  localparam int CFG_IDX_W  = 4;
  localparam int DEPTH_W    = 4;

  // Internal code, holds 0..NUM_POSITIONS.
  localparam int CODE_W = $clog2(NUM_POSITIONS + 1);

  // Signed centre: safe voltage less the largest possible total drop.
  localparam int MAX_DROP = (15 + 2 + NUM_POSITIONS) * 1023;
  localparam int CTR_W    = $clog2(8191 + MAX_DROP + 1) + 1;
  localparam int DIFF_W   = CTR_W + 1;

  // Window half widths in mV.
  localparam int HALF_FIXED_MV = 105;
  localparam int HALF_CAL_MV   = 70;

  // Fixed strip centres in mV.
  localparam int FIXED_COUNT = 13;
  localparam int FIXED_MV [FIXED_COUNT] = '{
    3110, 2870, 2640, 2410, 2180, 1950, 1720, 1490, 1260, 1020, 790, 560, 330
  };

  // Reset values of the registers.
  localparam logic [SAFE_W-1:0]  SAFE_RST  = SAFE_W'(3110);
  localparam logic [SLOPE_W-1:0] SLOPE_RST = SLOPE_W'(230);
  localparam logic [BS_W-1:0]    BS_RST    = BS_W'(1);

  // Register indexes on the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STRIP_TYPE  = 4'd0,
    REG_SAFE_MV     = 4'd1,
    REG_SLOPE_MV    = 4'd2,
    REG_BS_DISTANCE = 4'd3
  } dspc_reg_t;

  // Strip types.
  localparam logic STRIP_FIXED = 1'b0;
  localparam logic STRIP_CAL   = 1'b1;

  typedef struct packed {
    logic               strip_type;
    logic [SAFE_W-1:0]  safe_mv;
    logic [SLOPE_W-1:0] slope_mv;
    logic [BS_W-1:0]    bs_distance;
  } dspc_cfg_t;

  // Word handed from cell to cell.
  typedef struct packed {
    logic [SAMPLE_W-1:0]     sample;
    logic signed [CTR_W-1:0] centre;
    logic                    done;
    logic [CODE_W-1:0]       code;
  } dspc_word_t;

  // Fixed table centre of a position (zero past the table).
  function automatic logic signed [CTR_W-1:0] fixed_centre(input logic [CODE_W-1:0] pos);
    logic signed [CTR_W-1:0] c;
    c = '0;
    for (int i = 0; i < FIXED_COUNT; i++) begin
      if (i < NUM_POSITIONS && pos == CODE_W'(i)) c = CTR_W'(FIXED_MV[i]);
    end
    return c;
  endfunction

  // Whether a position has a fixed table window at all.
  function automatic logic fixed_has(input logic [CODE_W-1:0] pos);
    logic h;
    h = 1'b0;
    for (int i = 0; i < FIXED_COUNT; i++) begin
      if (i < NUM_POSITIONS && pos == CODE_W'(i)) h = 1'b1;
    end
    return h;
  endfunction

endpackage

`default_nettype wire

@@ rtl/depth_strip_position_classifier_unit.sv @@
// Channel | Dir | Signals                                   | Word
// --------+-----+-------------------------------------------+---------------------------
// in      | in  | in_valid, in_ready, sample_mv             | one voltage sample, mV
// out     | out | out_valid, out_ready, depth_code          | one depth code per sample
// cfg     | in  | cfg_valid, cfg_ready, cfg_index, cfg_data | one register write
//
// One sample enters per cycle while the chain is not stalled; each word walks a
// chain of NUM_POSITIONS cells, one window test per cell, to the output register.
// Synchronous reset empties the chain and loads the register reset values.
// A result waiting in the last cell with out_ready low stalls the whole chain,
// and in_ready drops for that cycle. Configuration writes are taken every cycle.
`default_nettype none

module depth_strip_position_classifier_unit (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [dspc_pkg::SAMPLE_W-1:0]  sample_mv,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [dspc_pkg::DEPTH_W-1:0]        depth_code,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [dspc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [dspc_pkg::DATA_W-1:0]    cfg_data
);
  import dspc_pkg::*;

  `include "assert_macros.svh"

  dspc_cfg_t  cfg;
  logic       adv;
  logic       vld [NUM_POSITIONS+1];
  dspc_word_t word [NUM_POSITIONS+1];

  dspc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Chain moves unless a result is held at the output.
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // Word entering the first cell.
  assign vld[0]         = in_valid;
  assign word[0].sample = sample_mv;
  assign word[0].centre = '0;
  assign word[0].done   = 1'b0;
  assign word[0].code   = CODE_W'(NUM_POSITIONS);

  for (genvar k = 0; k < NUM_POSITIONS; k++) begin : g_cell
    dspc_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .pos      (CODE_W'(k)),
      .cfg      (cfg),
      .up_valid (vld[k]),
      .up_word  (word[k]),
      .dn_valid (vld[k+1]),
      .dn_word  (word[k+1])
    );
  end

  // Last cell is the output register.
  assign out_valid  = vld[NUM_POSITIONS];
  assign depth_code = DEPTH_W'(word[NUM_POSITIONS].code);

  // Checks
  `DSPC_ASSERT_ALWAYS(a_rst_empty, rst |=> !out_valid, "output valid right after reset")
  `DSPC_ASSERT(a_code_range, out_valid |-> (NUM_POSITIONS > 15) || (depth_code <= DEPTH_W'(NUM_POSITIONS)), "depth code out of range")
  `DSPC_ASSERT(a_stall_src, !in_ready |-> out_valid && !out_ready, "stall without a held result")

endmodule

`default_nettype wire

@@ rtl/dspc_cfg.sv @@
`default_nettype none

module dspc_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [dspc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [dspc_pkg::DATA_W-1:0]    cfg_data,
  output dspc_pkg::dspc_cfg_t                cfg
);
  import dspc_pkg::*;

  // Writes are always taken.
  assign cfg_ready = 1'b1;

  // Register file; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.strip_type  <= STRIP_FIXED;
      cfg.safe_mv     <= SAFE_RST;
      cfg.slope_mv    <= SLOPE_RST;
      cfg.bs_distance <= BS_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_STRIP_TYPE:  cfg.strip_type  <= cfg_data[0];
        REG_SAFE_MV:     cfg.safe_mv     <= cfg_data[SAFE_W-1:0];
        REG_SLOPE_MV:    cfg.slope_mv    <= cfg_data[SLOPE_W-1:0];
        REG_BS_DISTANCE: cfg.bs_distance <= cfg_data[BS_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/dspc_cell.sv @@
`default_nettype none

module dspc_cell (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        adv,
  input  wire logic [dspc_pkg::CODE_W-1:0] pos,
  input  wire dspc_pkg::dspc_cfg_t         cfg,
  input  wire logic                        up_valid,
  input  wire dspc_pkg::dspc_word_t        up_word,
  output logic                             dn_valid,
  output dspc_pkg::dspc_word_t             dn_word
);
  import dspc_pkg::*;

  logic [SAFE_W+SLOPE_W-1:0] bs_drop;
  logic signed [CTR_W-1:0]   cal_centre;
  logic signed [CTR_W-1:0]   centre;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [DIFF_W-1:0]  half;
  logic                      has_win;
  logic                      hit;
  dspc_word_t                word_next;

  // Calibrated centre steps down from the previous cell's centre; position 0 starts at the safe voltage.
  assign bs_drop = (SAFE_W+SLOPE_W)'(cfg.bs_distance) * (SAFE_W+SLOPE_W)'(cfg.slope_mv);

  always_comb begin
    if (pos == CODE_W'(0)) begin
      cal_centre = CTR_W'(cfg.safe_mv);
    end else if (pos == CODE_W'(1)) begin
      cal_centre = up_word.centre - CTR_W'(bs_drop);
    end else if (pos == CODE_W'(2)) begin
      cal_centre = up_word.centre - CTR_W'({cfg.slope_mv, 1'b0});
    end else begin
      cal_centre = up_word.centre - CTR_W'(cfg.slope_mv);
    end
  end

  // Window of this position for the active strip type.
  always_comb begin
    if (cfg.strip_type == STRIP_CAL) begin
      centre  = cal_centre;
      half    = DIFF_W'(HALF_CAL_MV);
      has_win = 1'b1;
    end else begin
      centre  = fixed_centre(pos);
      half    = DIFF_W'(HALF_FIXED_MV);
      has_win = fixed_has(pos);
    end
  end

  // Open interval test on sample - centre.
  assign diff = DIFF_W'({1'b0, up_word.sample}) - DIFF_W'(centre);
  assign hit  = has_win && (diff > -half) && (diff < half);

  // First hit along the chain keeps its code.
  always_comb begin
    word_next        = up_word;
    word_next.centre = cal_centre;
    if (!up_word.done && hit) begin
      word_next.done = 1'b1;
      word_next.code = pos;
    end
  end

  // Stage register.
  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (adv) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dn_word <= word_next;
    end
  end

endmodule

`default_nettype wire
